>>> rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the sensor filter chain
// Fixed-point formats, register indexes, the request/response structs of the
// divider and the request struct of the shared multiplier.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int VALUE_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 16;

  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Kalman variance stays below 2^26 (1000.0 at reset is the peak).
  localparam int VAR_W = 26;

  // Divider: remainder and divisor width, low-part width and step count width.
  localparam int DIV_W     = 27;
  localparam int DIV_LOW_W = 24;
  localparam int DIV_CNT_W = 5;

  // Shared multiplier operands.
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Constant divides by reciprocal: floor(m / d) = (m * RECIP_d) >> RECIP_SHIFT,
  // exact for every m below 2^26.
  localparam int RECIP_SHIFT = 27;
  localparam logic [MUL_A_W-1:0] RECIP_3 = MUL_A_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam logic [MUL_A_W-1:0] RECIP_5 = MUL_A_W'(((1 << RECIP_SHIFT) + 4) / 5);

  localparam logic [VAR_W-1:0] GAIN_ONE = VAR_W'(1) << GAIN_FRAC_BITS;
  localparam logic [VAR_W-1:0] KAL_Q    = VAR_W'(((1 << GAIN_FRAC_BITS) + 5) / 10);
  localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(1000 << GAIN_FRAC_BITS);
  localparam logic [CFG_DATA_W-1:0] SLEW_STEP_RESET = CFG_DATA_W'(10 << VALUE_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEDIAN_EN  = 3'd0,
    CFG_AVERAGE_EN = 3'd1,
    CFG_KALMAN_EN  = 3'd2,
    CFG_SLEW_EN    = 3'd3,
    CFG_SMOOTH_EN  = 3'd4,
    CFG_SLEW_STEP  = 3'd5
  } sfc_cfg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_LOW_W-1:0] low;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     divisor;
  } sfc_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_LOW_W-1:0] quotient;
  } sfc_div_rsp_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } sfc_mul_req_t;

endpackage

>>> rtl/sfc_if.sv
// ----------------------------------------------------------------------------
// sfc_if: item channels of the sensor filter chain
// Valid/ready channels for raw samples and filtered results.
// ----------------------------------------------------------------------------
interface sfc_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sfc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [sfc_pkg::VALUE_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

>>> rtl/sfc_divider.sv
// ----------------------------------------------------------------------------
// sfc_divider: restoring divider
// One quotient bit per cycle. The remainder starts at rem_init (below the
// divisor) and the bits of low are shifted in from the top.
// ----------------------------------------------------------------------------
module sfc_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfc_pkg::sfc_div_req_t div_req,
  output sfc_pkg::sfc_div_rsp_t div_rsp
);

  logic [sfc_pkg::DIV_W-1:0]     rem_r;
  logic [sfc_pkg::DIV_W-1:0]     divisor_r;
  logic [sfc_pkg::DIV_LOW_W-1:0] low_r;
  logic [sfc_pkg::DIV_LOW_W-1:0] quo_r;
  logic [sfc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [sfc_pkg::DIV_W:0]   trial;
  logic                      fits;
  logic [sfc_pkg::DIV_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, low_r[sfc_pkg::DIV_LOW_W-1]};
    fits     = (trial >= {1'b0, divisor_r});
    rem_step = fits ? sfc_pkg::DIV_W'(trial - {1'b0, divisor_r})
                    : trial[sfc_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start && !busy_r) begin
        rem_r     <= div_req.rem_init;
        low_r     <= div_req.low;
        divisor_r <= div_req.divisor;
        quo_r     <= '0;
        cnt_r     <= div_req.steps;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_step;
        low_r <= {low_r[sfc_pkg::DIV_LOW_W-2:0], 1'b0};
        quo_r <= {quo_r[sfc_pkg::DIV_LOW_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == sfc_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.busy     = busy_r;
  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = quo_r;

endmodule

>>> rtl/sfc_mul.sv
// ----------------------------------------------------------------------------
// sfc_mul: shared registered multiplier
// Signed product of the two operands, registered when enabled.
// ----------------------------------------------------------------------------
module sfc_mul (
  input  logic                                clk,
  input  sfc_pkg::sfc_mul_req_t               mul_req,
  output logic signed [sfc_pkg::MUL_P_W-1:0]  product
);

  logic signed [sfc_pkg::MUL_P_W-1:0] product_r;

  always_ff @(posedge clk) begin
    if (mul_req.en) begin
      product_r <= mul_req.a * mul_req.b;
    end
  end

  assign product = product_r;

endmodule

>>> rtl/sensor_filter_chain.sv
// ----------------------------------------------------------------------------
// sensor_filter_chain: five-stage switchable sensor filter
// Median of three, three-entry average, scalar Kalman, slew limit and
// 0.8/0.2 low-pass applied in order, one result item per sample item.
// ----------------------------------------------------------------------------
// One item is worked at a time by a small sequencer; in_ch.ready is high only
// while it is idle, and the result waits in an output register so the next
// sample can be taken before the result is collected. With every stage off an
// item passes six sequencer steps after it is taken (median, average, Kalman,
// slew, low-pass, done). The Kalman stage adds S_KAL_DIV, S_KAL_MUL1 and
// S_KAL_MUL2: the gain runs through the restoring divider at one quotient bit
// per cycle (16 steps, then the result), then two registered products. The
// constant divides (sum by 3 at the end of an average batch, low-pass by 5) are
// reciprocal products on the shared multiplier and add one step each (S_AVG_DIV,
// S_SM_DIV). A result not yet collected from the output register holds the
// sequencer in its last step. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no item is in
// flight; the block itself does not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module sensor_filter_chain (
  input  logic                               clk,
  input  logic                               rst_n,
  sfc_sample_if.sink                         in_ch,
  sfc_result_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VW = sfc_pkg::VALUE_W;
  localparam int SW = sfc_pkg::SAMPLE_W;
  localparam int PW = sfc_pkg::MUL_P_W;
  localparam int GF = sfc_pkg::GAIN_FRAC_BITS;
  localparam int VF = sfc_pkg::VALUE_FRAC_BITS;
  localparam int MAG_W = VW + 3;   // 4*prev + r, and the average total

  typedef enum logic [3:0] {
    S_IDLE, S_MED, S_AVG, S_AVG_DIV, S_KAL, S_KAL_DIV, S_KAL_MUL1,
    S_KAL_MUL2, S_SLEW, S_SMOOTH, S_SM_DIV, S_DONE
  } state_t;

  // configuration
  logic                          med_en_r, avg_en_r, kal_en_r, slew_en_r, smooth_en_r;
  logic [sfc_pkg::CFG_DATA_W-1:0] slew_step_r;

  // sequencer and filter state
  state_t                        state_r, state_nxt;
  logic signed [SW-1:0]          sample_r, sample_nxt;
  logic signed [VW-1:0]          val_r, val_nxt;
  logic                          neg_r, neg_nxt;
  logic signed [SW-1:0]          med_store_r [3];
  logic signed [SW-1:0]          med_store_nxt [3];
  logic [1:0]                    med_fill_r, med_fill_nxt;
  logic signed [VW-1:0]          avg_store_r [3];
  logic signed [VW-1:0]          avg_store_nxt [3];
  logic signed [VW+1:0]          avg_total_r, avg_total_nxt;
  logic [1:0]                    avg_slot_r, avg_slot_nxt;
  logic signed [VW-1:0]          est_r, est_nxt;
  logic [sfc_pkg::VAR_W-1:0]     var_r, var_nxt;
  logic [GF-1:0]                 gain_r, gain_nxt;
  logic signed [VW-1:0]          slew_prev_r, slew_prev_nxt;
  logic signed [VW-1:0]          smooth_prev_r, smooth_prev_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]          out_data_r, out_data_nxt;

  sfc_pkg::sfc_div_req_t         div_req;
  sfc_pkg::sfc_div_rsp_t         div_rsp;
  sfc_pkg::sfc_mul_req_t         mul_req;
  logic signed [PW-1:0]          product;

  // working values
  logic signed [SW-1:0]          med_val;
  logic signed [VW+1:0]          total_new;
  logic signed [MAG_W-1:0]       wide_val;
  logic [MAG_W-1:0]              mag_val;
  logic signed [VW:0]            kal_diff;
  logic signed [VW+1:0]          slew_hi, slew_lo, slew_in;
  logic signed [VW-1:0]          slew_out;
  logic [VW-1:0]                 recip_quo;
  logic signed [VW-1:0]          quo_signed;

  sfc_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  sfc_mul u_mul (
    .clk     (clk),
    .mul_req (mul_req),
    .product (product)
  );

  function automatic logic signed [SW-1:0] median3(
    input logic signed [SW-1:0] a_in,
    input logic signed [SW-1:0] b_in,
    input logic signed [SW-1:0] c_in
  );
    logic signed [SW-1:0] lo, hi;
    lo = (a_in > b_in) ? b_in : a_in;
    hi = (a_in > b_in) ? a_in : b_in;
    if (hi > c_in) hi = c_in;
    return (lo > hi) ? lo : hi;
  endfunction

  // product / 2^GF, nearest, ties away from zero
  function automatic logic signed [PW-1:0] round_gain(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    q   = (mag + (PW'(1) << (GF - 1))) >> GF;
    return v[PW-1] ? -$signed(q) : $signed(q);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      med_en_r    <= 1'b0;
      avg_en_r    <= 1'b0;
      kal_en_r    <= 1'b0;
      slew_en_r   <= 1'b0;
      smooth_en_r <= 1'b0;
      slew_step_r <= sfc_pkg::SLEW_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfc_pkg::CFG_MEDIAN_EN:  med_en_r    <= cfg_data[0];
        sfc_pkg::CFG_AVERAGE_EN: avg_en_r    <= cfg_data[0];
        sfc_pkg::CFG_KALMAN_EN:  kal_en_r    <= cfg_data[0];
        sfc_pkg::CFG_SLEW_EN:    slew_en_r   <= cfg_data[0];
        sfc_pkg::CFG_SMOOTH_EN:  smooth_en_r <= cfg_data[0];
        sfc_pkg::CFG_SLEW_STEP:  slew_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sample_nxt      = sample_r;
    val_nxt         = val_r;
    neg_nxt         = neg_r;
    med_store_nxt   = med_store_r;
    med_fill_nxt    = med_fill_r;
    avg_store_nxt   = avg_store_r;
    avg_total_nxt   = avg_total_r;
    avg_slot_nxt    = avg_slot_r;
    est_nxt         = est_r;
    var_nxt         = var_r;
    gain_nxt        = gain_r;
    slew_prev_nxt   = slew_prev_r;
    smooth_prev_nxt = smooth_prev_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_data_nxt    = out_data_r;

    div_req          = '0;
    mul_req          = '0;

    med_val   = '0;
    total_new = '0;
    wide_val  = '0;
    mag_val   = '0;
    kal_diff  = (VW+1)'(val_r) - (VW+1)'(est_r);
    slew_in   = (VW+2)'(val_r);
    slew_hi   = (VW+2)'(slew_prev_r) + $signed((VW+2)'(slew_step_r));
    slew_lo   = (VW+2)'(slew_prev_r) - $signed((VW+2)'(slew_step_r));
    slew_out  = val_r;
    // reciprocal product of the rounded magnitude, sign restored
    recip_quo  = product[sfc_pkg::RECIP_SHIFT +: VW];
    quo_signed = neg_r ? VW'(-$signed(recip_quo)) : $signed(recip_quo);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt = in_ch.sample;
          state_nxt  = S_MED;
        end
      end

      S_MED: begin
        val_nxt = VW'(sample_r) <<< VF;
        if (med_en_r) begin
          med_store_nxt[med_fill_r] = sample_r;
          if (med_fill_r == 2'd2) begin
            med_val      = median3(med_store_nxt[0], med_store_nxt[1], med_store_nxt[2]);
            val_nxt      = VW'(med_val) <<< VF;
            med_fill_nxt = 2'd0;
          end else begin
            med_fill_nxt = med_fill_r + 2'd1;
          end
        end
        state_nxt = S_AVG;
      end

      S_AVG: begin
        state_nxt = S_KAL;
        if (avg_en_r) begin
          total_new     = avg_total_r - (VW+2)'(avg_store_r[avg_slot_r]) + (VW+2)'(val_r);
          avg_total_nxt = total_new;
          avg_store_nxt[avg_slot_r] = val_r;
          if (avg_slot_r == 2'd2) begin
            // batch end: round(total / 3)
            avg_slot_nxt    = 2'd0;
            wide_val        = MAG_W'(total_new);
            mag_val         = (wide_val[MAG_W-1] ? MAG_W'(-wide_val) : MAG_W'(wide_val))
                              + MAG_W'(1);
            neg_nxt         = wide_val[MAG_W-1];
            mul_req.en      = 1'b1;
            mul_req.a       = $signed(sfc_pkg::RECIP_3);
            mul_req.b       = $signed(sfc_pkg::MUL_B_W'(mag_val));
            state_nxt       = S_AVG_DIV;
          end else begin
            avg_slot_nxt = avg_slot_r + 2'd1;
          end
        end
      end

      S_AVG_DIV: begin
        val_nxt   = quo_signed;
        state_nxt = S_KAL;
      end

      S_KAL: begin
        if (kal_en_r) begin
          // gain = floor(P * 2^GF / (P + 1.0))
          div_req.start    = 1'b1;
          div_req.rem_init = sfc_pkg::DIV_W'(var_r);
          div_req.low      = '0;
          div_req.steps    = sfc_pkg::DIV_CNT_W'(GF);
          div_req.divisor  = sfc_pkg::DIV_W'(var_r) + sfc_pkg::DIV_W'(sfc_pkg::GAIN_ONE);
          state_nxt        = S_KAL_DIV;
        end else begin
          state_nxt = S_SLEW;
        end
      end

      S_KAL_DIV: begin
        if (div_rsp.done) begin
          gain_nxt  = div_rsp.quotient[GF-1:0];
          mul_req.en = 1'b1;
          mul_req.a  = $signed(sfc_pkg::MUL_A_W'(div_rsp.quotient[GF-1:0]));
          mul_req.b  = sfc_pkg::MUL_B_W'(kal_diff);
          state_nxt  = S_KAL_MUL1;
        end
      end

      S_KAL_MUL1: begin
        est_nxt    = VW'(PW'(est_r) + round_gain(product));
        mul_req.en = 1'b1;
        mul_req.a  = $signed(sfc_pkg::MUL_A_W'(sfc_pkg::GAIN_ONE[GF:0] - {1'b0, gain_r}));
        mul_req.b  = $signed({1'b0, var_r});
        state_nxt  = S_KAL_MUL2;
      end

      S_KAL_MUL2: begin
        var_nxt   = sfc_pkg::VAR_W'(round_gain(product)) + sfc_pkg::KAL_Q;
        val_nxt   = est_r;
        state_nxt = S_SLEW;
      end

      S_SLEW: begin
        if (slew_en_r) begin
          if (slew_in > slew_hi) begin
            slew_out = VW'(slew_hi);
          end else if (slew_in < slew_lo) begin
            slew_out = VW'(slew_lo);
          end
          val_nxt       = slew_out;
          slew_prev_nxt = slew_out;
        end
        state_nxt = S_SMOOTH;
      end

      S_SMOOTH: begin
        if (smooth_en_r) begin
          // round((4 * previous + input) / 5)
          wide_val         = (MAG_W'(smooth_prev_r) <<< 2) + MAG_W'(val_r);
          mag_val          = (wide_val[MAG_W-1] ? MAG_W'(-wide_val) : MAG_W'(wide_val))
                             + MAG_W'(2);
          neg_nxt          = wide_val[MAG_W-1];
          mul_req.en       = 1'b1;
          mul_req.a        = $signed(sfc_pkg::RECIP_5);
          mul_req.b        = $signed(sfc_pkg::MUL_B_W'(mag_val));
          state_nxt        = S_SM_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SM_DIV: begin
        val_nxt         = quo_signed;
        smooth_prev_nxt = quo_signed;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        // wait for a free output register
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = val_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      neg_r         <= 1'b0;
      med_store_r   <= '{default: '0};
      med_fill_r    <= 2'd0;
      avg_store_r   <= '{default: '0};
      avg_total_r   <= '0;
      avg_slot_r    <= 2'd0;
      est_r         <= '0;
      var_r         <= sfc_pkg::VAR_RESET;
      gain_r        <= '0;
      slew_prev_r   <= '0;
      smooth_prev_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      neg_r         <= neg_nxt;
      med_store_r   <= med_store_nxt;
      med_fill_r    <= med_fill_nxt;
      avg_store_r   <= avg_store_nxt;
      avg_total_r   <= avg_total_nxt;
      avg_slot_r    <= avg_slot_nxt;
      est_r         <= est_nxt;
      var_r         <= var_nxt;
      gain_r        <= gain_nxt;
      slew_prev_r   <= slew_prev_nxt;
      smooth_prev_r <= smooth_prev_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_data_r;

`ifndef SYNTHESIS
  // divider results arrive only while the sequencer waits for one
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_KAL_DIV))
    else $error("divider result with no waiting stage");

  // the divider is never restarted mid-division
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Kalman gain stays below one
  a_gain_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KAL_DIV && div_rsp.done) |-> (div_rsp.quotient[sfc_pkg::DIV_LOW_W-1:GF] == '0))
    else $error("Kalman gain not below one");

  // batch positions stay within three
  a_batch_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (med_fill_r != 2'd3) && (avg_slot_r != 2'd3))
    else $error("median fill or average slot out of range");
`endif

endmodule

>>> verif/tb_sensor_filter_chain.sv
// ----------------------------------------------------------------------------
// tb_sensor_filter_chain: self-checking testbench of the sensor filter chain
// Drives raw samples over the valid/ready sample channel and checks every
// filtered result against an in-bench predictor of the five stages. Directed
// items cover the field extremes, each stage alone and batches broken by a
// stage switch; random traffic then runs under several register settings,
// with the sender and receiver stalling at random.
// ----------------------------------------------------------------------------
module tb_sensor_filter_chain;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  // Run limits
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 200;   // well past the longest item
  localparam int PRINT_LIMIT = 100;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Fixed-point constants of the predictor
  localparam longint VALUE_MAX  = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint VALUE_MIN  = -(longint'(1) << (VALUE_W - 1));
  localparam longint VALUE_ONE  = longint'(1) << VALUE_FRAC_BITS;
  localparam longint GAIN_UNIT  = longint'(1) << GAIN_FRAC_BITS;
  localparam longint KAL_NOISE  = (GAIN_UNIT + 5) / 10;         // Q = 0.1
  localparam longint KAL_START  = longint'(1000) << GAIN_FRAC_BITS;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [VALUE_W-1:0]  filtered;
  } filtered_due_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfc_sample_if sample_ch();
  sfc_result_if result_ch();

  sensor_filter_chain u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the state of each stage
  // --------------------------------------------------------------------------
  bit     median_on, average_on, kalman_on, slew_on, smooth_on;
  longint slew_limit;

  longint med_keep [3];
  int     med_count;
  longint avg_keep [3];
  longint avg_sum;
  int     avg_slot;
  longint kal_est;
  longint kal_var;
  longint slew_last;
  longint lp_last;

  // Results still owed by the block, oldest first
  filtered_due_t filtered_due [$];
  filtered_due_t due_now;

  int mismatches;
  int results_seen;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int walk_level;

  // --------------------------------------------------------------------------
  // Arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic longint sat_value(input longint v);
    if (v > VALUE_MAX) return VALUE_MAX;
    if (v < VALUE_MIN) return VALUE_MIN;
    return v;
  endfunction

  // Division by a positive constant, nearest, ties away from zero
  function automatic longint div_nearest(input longint v, input longint d);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + d / 2) / d;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint shr_nearest(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint mid_of_three(input longint a, input longint b, input longint c);
    longint t;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (b > c) b = c;
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // Register write as the block sees it: unknown index ignored, data
  // truncated to the register width
  // --------------------------------------------------------------------------
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MEDIAN_EN:  median_on  = data[0];
      CFG_AVERAGE_EN: average_on = data[0];
      CFG_KALMAN_EN:  kalman_on  = data[0];
      CFG_SLEW_EN:    slew_on    = data[0];
      CFG_SMOOTH_EN:  smooth_on  = data[0];
      CFG_SLEW_STEP:  slew_limit = longint'(data);
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // One sample through the five stages; updates the stage state
  // --------------------------------------------------------------------------
  function automatic logic signed [VALUE_W-1:0] predict_filtered(
      input logic signed [SAMPLE_W-1:0] s);
    longint r;
    longint gain;
    longint diff;
    longint var_now;
    int     slot;
    r = sat_value(longint'(s) * VALUE_ONE);

    // batched median: every third stored sample gives the median
    if (median_on) begin
      med_keep[med_count % 3] = longint'(s);
      med_count++;
      if (med_count >= 3) begin
        r = sat_value(mid_of_three(med_keep[0], med_keep[1], med_keep[2]) * VALUE_ONE);
        med_count = 0;
      end
    end

    // running sum of three; mean out when the slot wraps
    if (average_on) begin
      slot = avg_slot % 3;
      avg_sum -= avg_keep[slot];
      avg_keep[slot] = r;
      avg_sum += r;
      avg_slot = (slot + 1) % 3;
      if (avg_slot == 0) r = div_nearest(avg_sum, 3);
    end

    // scalar Kalman, R = 1.0, Q = 0.1
    if (kalman_on) begin
      var_now = kal_var;
      gain    = (var_now << GAIN_FRAC_BITS) / (var_now + GAIN_UNIT);
      diff    = r - kal_est;
      kal_est += shr_nearest(gain * diff, GAIN_FRAC_BITS);
      kal_var = shr_nearest((GAIN_UNIT - gain) * var_now, GAIN_FRAC_BITS) + KAL_NOISE;
      r = kal_est;
    end

    if (slew_on) begin
      if (r > slew_last + slew_limit) r = slew_last + slew_limit;
      else if (r < slew_last - slew_limit) r = slew_last - slew_limit;
      slew_last = r;
    end

    // 0.8 * previous + 0.2 * input
    if (smooth_on) begin
      r = div_nearest(4 * lp_last + r, 5);
      lp_last = r;
    end

    return VALUE_W'(sat_value(r));
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog, receiver
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls at random, one draw per cycle
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Each accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (filtered_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d (filtered %0d) with no item outstanding",
                                results_seen, result_ch.filtered));
      end else begin
        due_now = filtered_due.pop_front();
        if (result_ch.filtered !== due_now.filtered)
          flag_mismatch($sformatf("result %0d: sample %0d filtered %0d, want %0d",
                                  results_seen, due_now.sample, result_ch.filtered,
                                  due_now.filtered));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Drives one item at a falling edge, after random idle cycles, and holds it
  // until the block takes it. valid stays high on return so back-to-back items
  // need no drop.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    bit going;
    going = 1'b0;
    while (!going) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) sample_ch.valid <= 1'b0;
      else going = 1'b1;
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    filtered_due.push_back('{sample: value, filtered: predict_filtered(value)});
  endtask

  // Stop sending and wait for every owed result; the block is idle after
  task automatic wait_all_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (filtered_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random stage enables (high bits junk) and a slew step biased to extremes
  task automatic load_setting(input bit all_on);
    logic [4:0]            on_bits;
    logic [CFG_DATA_W-1:0] step;
    on_bits = all_on ? 5'h1f : 5'($urandom);
    case ($urandom_range(4))
      0:       step = '0;
      1:       step = '1;
      2:       step = CFG_DATA_W'($urandom_range(1, 64));
      3:       step = CFG_DATA_W'($urandom_range(256, 4096));
      default: step = CFG_DATA_W'($urandom);
    endcase
    write_register(CFG_MEDIAN_EN,  {(CFG_DATA_W-1)'($urandom), on_bits[0]});
    write_register(CFG_AVERAGE_EN, {(CFG_DATA_W-1)'($urandom), on_bits[1]});
    write_register(CFG_KALMAN_EN,  {(CFG_DATA_W-1)'($urandom), on_bits[2]});
    write_register(CFG_SLEW_EN,    {(CFG_DATA_W-1)'($urandom), on_bits[3]});
    write_register(CFG_SMOOTH_EN,  {(CFG_DATA_W-1)'($urandom), on_bits[4]});
    write_register(CFG_SLEW_STEP,  step);
    if ($urandom_range(2) == 0)
      write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
  endtask

  // Mostly a bounded random walk (keeps slew and Kalman busy), some full-range
  // values and some extremes
  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3: return SAMPLE_W'($urandom);
      default: begin
        walk_level += $urandom_range(400) - 200;
        if (walk_level > 32767) walk_level = 32767;
        if (walk_level < -32768) walk_level = -32768;
        return SAMPLE_W'(walk_level);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // All stages off after reset: value is the sample shifted into fixed point
  task automatic test_passthrough();
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'shffff);
    send_sample(16'sh5555);
  endtask

  // Junk high bits on an enable, undecoded indexes, slew step at its maximum
  task automatic test_register_port();
    wait_all_results();
    write_register(CFG_MEDIAN_EN, 16'hfffe);   // bit 0 clear: stays off
    write_register(CFG_SPARE_LO, 16'hffff);
    write_register(CFG_SPARE_HI, 16'hffff);
    send_sample(16'shaaaa);
    wait_all_results();
    write_register(CFG_SLEW_STEP, 16'hffff);
    write_register(CFG_SLEW_EN, 16'h8001);
    send_sample(16'sh7fff);
    wait_all_results();
    write_register(CFG_SLEW_EN, 16'h0000);
  endtask

  // Median batch at the extremes, then a batch split by switching the stage off
  task automatic test_median();
    wait_all_results();
    write_register(CFG_MEDIAN_EN, 16'h0001);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd7);
    send_sample(16'sd100);
    wait_all_results();
    write_register(CFG_MEDIAN_EN, 16'h0000);
    send_sample(-16'sd5);
    wait_all_results();
    write_register(CFG_MEDIAN_EN, 16'h0001);
    send_sample(16'sd200);
    send_sample(16'sd50);
    wait_all_results();
    write_register(CFG_MEDIAN_EN, 16'h0000);
  endtask

  // Average of extremes, then a batch split by switching the stage off
  task automatic test_average();
    wait_all_results();
    write_register(CFG_AVERAGE_EN, 16'h0001);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd3);
    wait_all_results();
    write_register(CFG_AVERAGE_EN, 16'h0000);
    send_sample(16'sd9);
    wait_all_results();
    write_register(CFG_AVERAGE_EN, 16'h0001);
    send_sample(16'sd4);
    send_sample(16'sd2);
    wait_all_results();
    write_register(CFG_AVERAGE_EN, 16'h0000);
  endtask

  // Kalman from its reset variance, a frozen slew limit, then the low-pass
  task automatic test_kalman_slew_smooth();
    wait_all_results();
    write_register(CFG_KALMAN_EN, 16'h0001);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    wait_all_results();
    write_register(CFG_KALMAN_EN, 16'h0000);
    write_register(CFG_SLEW_STEP, 16'h0000);
    write_register(CFG_SLEW_EN, 16'h0001);
    send_sample(16'sh8000);
    wait_all_results();
    write_register(CFG_SLEW_EN, 16'h0000);
    write_register(CFG_SLEW_STEP, SLEW_STEP_RESET);
    write_register(CFG_SMOOTH_EN, 16'h0001);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Random samples under four register settings; the first is all stages on.
  // Somewhere in each setting the sender holds off until the pipe drains.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int items);
    int per_setting;
    int hold_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    per_setting   = items / 4;
    for (int pick = 0; pick < 4; pick++) begin
      wait_all_results();
      load_setting(pick == 0);
      hold_at = $urandom_range(per_setting - 1);
      for (int n = 0; n < per_setting; n++) begin
        if (n == hold_at) wait_all_results();
        send_sample(next_sample());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    mismatches       = 0;
    results_seen     = 0;
    cycle_count      = 0;
    walk_level       = 0;

    // predictor reset state
    median_on   = 1'b0;
    average_on  = 1'b0;
    kalman_on   = 1'b0;
    slew_on     = 1'b0;
    smooth_on   = 1'b0;
    slew_limit  = longint'(SLEW_STEP_RESET);
    med_keep    = '{0, 0, 0};
    med_count   = 0;
    avg_keep    = '{0, 0, 0};
    avg_sum     = 0;
    avg_slot    = 0;
    kal_est     = 0;
    kal_var     = KAL_START;
    slew_last   = 0;
    lp_last     = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_register_port();
    test_median();
    test_average();
    test_kalman_slew_smooth();

    test_random_traffic(9, 60, 536);
    test_random_traffic(60, 9, 536);
    test_random_traffic(0, 0, 536);

    // drain, then leave room for any stray result
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/sfc_pkg.sv
rtl/sfc_if.sv
rtl/sfc_divider.sv
rtl/sfc_mul.sv
rtl/sensor_filter_chain.sv
verif/tb_sensor_filter_chain.sv
